// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

// ----- rtl/tli_pkg.sv -----
`timescale 1ns / 1ps
package tli_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_RUN    = 2'd2;
    localparam logic [1:0] CMD_SUPPLY = 2'd3;

    localparam logic [2:0] OP_RIGHT = 3'd0;
    localparam logic [2:0] OP_LEFT  = 3'd1;
    localparam logic [2:0] OP_INC   = 3'd2;
    localparam logic [2:0] OP_DEC   = 3'd3;
    localparam logic [2:0] OP_OUT   = 3'd4;
    localparam logic [2:0] OP_IN    = 3'd5;
    localparam logic [2:0] OP_OPEN  = 3'd6;
    localparam logic [2:0] OP_CLOSE = 3'd7;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_OUTPUT    = 4'd1;
    localparam logic [3:0] ST_NEED      = 4'd2;
    localparam logic [3:0] ST_DONE      = 4'd3;
    localparam logic [3:0] ST_UNDER     = 4'd4;
    localparam logic [3:0] ST_UNMATCHED = 4'd5;
    localparam logic [3:0] ST_OVER      = 4'd6;
    localparam logic [3:0] ST_LOOPFULL  = 4'd7;
    localparam logic [3:0] ST_FULL      = 4'd8;
    localparam logic [3:0] ST_BUDGET    = 4'd9;

    localparam logic [1:0] MODE_READY = 2'd0;
    localparam logic [1:0] MODE_WAIT  = 2'd1;
    localparam logic [1:0] MODE_HALT  = 2'd2;

    localparam logic [31:0] BUDGET_RESET = 32'd65535;

    // controller to datapath
    typedef struct packed {
        logic clear_start;  // begin tape clear sweep, reset pointers
        logic clear_step;   // write zero at sweep address
        logic load;         // append symbol
        logic fetch;        // read program and tape at current pointers
        logic exec;         // execute fetched op
        logic skip_start;   // enter skip mode
        logic skip_step;    // consume one symbol of a skip
        logic supply;       // write byte to cell, advance pc
        logic budget_clr;
    } tli_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       clear_done;
        logic       at_end;
        logic       budget_out;
        logic [2:0] op;
        logic       cell_zero;
        logic       at_right;
        logic       at_left;
        logic       stack_empty;
        logic       stack_full;
        logic       skip_done;
        logic       full;
    } tli_stat_t;

    function automatic logic [3:0] sym_code(input logic [7:0] c);
        case (c)
            8'h3E: sym_code = {1'b1, OP_RIGHT};
            8'h3C: sym_code = {1'b1, OP_LEFT};
            8'h2B: sym_code = {1'b1, OP_INC};
            8'h2D: sym_code = {1'b1, OP_DEC};
            8'h2E: sym_code = {1'b1, OP_OUT};
            8'h2C: sym_code = {1'b1, OP_IN};
            8'h5B: sym_code = {1'b1, OP_OPEN};
            8'h5D: sym_code = {1'b1, OP_CLOSE};
            default: sym_code = 4'd0;
        endcase
    endfunction

endpackage

// ----- rtl/tli_if.sv -----
`timescale 1ns / 1ps
interface tli_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    modport source (output valid, cmd, data_byte, input ready);
    modport sink (input valid, cmd, data_byte, output ready);
endinterface

interface tli_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [3:0] status;
    modport source (output valid, out_byte, status, input ready);
    modport sink (input valid, out_byte, status, output ready);
endinterface

interface tli_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- rtl/tli_datapath.sv -----
`timescale 1ns / 1ps
module tli_datapath #(
    parameter int PROGRAM_DEPTH = 4096,
    parameter int TAPE_DEPTH = 1024,
    parameter int LOOP_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tli_pkg::tli_cmd_t ctl,
    input  logic [7:0]        data_byte,
    input  logic [31:0]       step_budget,
    output tli_pkg::tli_stat_t stat,
    output logic [7:0]        cell_value
);
    import tli_pkg::*;

    localparam int PW = $clog2(PROGRAM_DEPTH);
    localparam int TW = $clog2(TAPE_DEPTH);
    localparam int LW = $clog2(LOOP_DEPTH);

    logic [2:0] prog_mem [PROGRAM_DEPTH];
    logic [7:0] tape_mem [TAPE_DEPTH];
    logic [PW-1:0] loop_mem [LOOP_DEPTH];

    logic [PW:0]   len_reg, len_next;
    logic [PW:0]   pc_reg, pc_next;
    logic [TW-1:0] tp_reg, tp_next;
    logic [LW:0]   sp_reg, sp_next;
    logic [TW:0]   clr_reg, clr_next;
    logic [31:0]   done_reg, done_next;
    logic [PW:0]   depth_reg, depth_next;
    logic [2:0]    op_reg;
    logic [7:0]    cell_reg;
    logic [PW-1:0] ret_reg;

    logic [3:0] sc;
    logic [7:0] cell_new;
    logic       cell_we;

    assign sc = sym_code(data_byte);

    always_comb
    begin
        len_next = len_reg;
        pc_next = pc_reg;
        tp_next = tp_reg;
        sp_next = sp_reg;
        clr_next = clr_reg;
        done_next = done_reg;
        depth_next = depth_reg;
        cell_we = 1'b0;
        cell_new = cell_reg;
        if (ctl.clear_start)
        begin
            len_next = '0;
            pc_next = '0;
            tp_next = '0;
            sp_next = '0;
            clr_next = '0;
        end
        if (ctl.clear_step)
            clr_next = clr_reg + 1'b1;
        if (ctl.load && sc[3])
            len_next = len_reg + 1'b1;
        if (ctl.budget_clr)
            done_next = '0;
        if (ctl.supply)
        begin
            cell_we = 1'b1;
            cell_new = data_byte;
            pc_next = pc_reg + 1'b1;
        end
        if (ctl.exec)
        begin
            done_next = done_reg + 1'b1;
            case (op_reg)
                OP_RIGHT:
                begin
                    tp_next = tp_reg + 1'b1;
                    pc_next = pc_reg + 1'b1;
                end
                OP_LEFT:
                begin
                    tp_next = tp_reg - 1'b1;
                    pc_next = pc_reg + 1'b1;
                end
                OP_INC:
                begin
                    cell_we = 1'b1;
                    cell_new = cell_reg + 8'd1;
                    pc_next = pc_reg + 1'b1;
                end
                OP_DEC:
                begin
                    cell_we = 1'b1;
                    cell_new = cell_reg - 8'd1;
                    pc_next = pc_reg + 1'b1;
                end
                OP_OUT: pc_next = pc_reg + 1'b1;
                OP_OPEN:
                begin
                    if (cell_reg != 8'd0)
                        sp_next = sp_reg + 1'b1;
                    pc_next = pc_reg + 1'b1;
                end
                OP_CLOSE:
                begin
                    if (cell_reg != 8'd0)
                        pc_next = {1'b0, ret_reg};
                    else
                    begin
                        sp_next = sp_reg - 1'b1;
                        pc_next = pc_reg + 1'b1;
                    end
                end
                default: pc_next = pc_reg;
            endcase
        end
        if (ctl.skip_start)
            depth_next = (PW+1)'(1);
        if (ctl.skip_step)
        begin
            // op_reg holds the symbol at pc
            if (op_reg == OP_OPEN)
                depth_next = depth_reg + 1'b1;
            else if (op_reg == OP_CLOSE)
                depth_next = depth_reg - 1'b1;
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            pc_reg <= '0;
            tp_reg <= '0;
            sp_reg <= '0;
            clr_reg <= '0;
            done_reg <= '0;
            depth_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
            pc_reg <= pc_next;
            tp_reg <= tp_next;
            sp_reg <= sp_next;
            clr_reg <= clr_next;
            done_reg <= done_next;
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && sc[3] && len_reg < (PW+1)'(PROGRAM_DEPTH))
            prog_mem[len_reg[PW-1:0]] <= sc[2:0];
        if (ctl.fetch)
            op_reg <= prog_mem[pc_reg[PW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear_step)
            tape_mem[clr_reg[TW-1:0]] <= 8'd0;
        else if (cell_we)
            tape_mem[tp_reg] <= cell_new;
        if (ctl.fetch)
            cell_reg <= tape_mem[tp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec && op_reg == OP_OPEN && cell_reg != 8'd0)
            loop_mem[sp_reg[LW-1:0]] <= pc_next[PW-1:0];
        if (ctl.fetch && sp_reg != '0)
            ret_reg <= loop_mem[sp_reg[LW-1:0] - 1'b1];
    end

    assign cell_value = cell_reg;
    assign stat.clear_done = (clr_reg == (TW+1)'(TAPE_DEPTH - 1)) && ctl.clear_step;
    assign stat.at_end = pc_reg >= len_reg;
    assign stat.budget_out = done_reg >= step_budget;
    assign stat.op = op_reg;
    assign stat.cell_zero = cell_reg == 8'd0;
    assign stat.at_right = tp_reg == TW'(TAPE_DEPTH - 1);
    assign stat.at_left = tp_reg == '0;
    assign stat.stack_empty = sp_reg == '0;
    assign stat.stack_full = sp_reg >= (LW+1)'(LOOP_DEPTH);
    assign stat.skip_done = depth_reg == '0;
    assign stat.full = len_reg >= (PW+1)'(PROGRAM_DEPTH);
endmodule

// ----- rtl/tli_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tli_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    tli_in_if.sink             in_ch,
    tli_out_if.source          out_ch,
    input  tli_pkg::tli_stat_t stat,
    input  logic [7:0]         cell_value,
    output tli_pkg::tli_cmd_t  ctl,
    output logic [7:0]         data_byte
);
    import tli_pkg::*;

    localparam logic [2:0] S_RESET = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CLEAR = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;
    localparam logic [2:0] S_SKIPF = 3'd5;
    localparam logic [2:0] S_SKIP  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] mode_reg, mode_next;
    logic [3:0] halt_reg, halt_next;
    logic [3:0] st_reg, st_next;
    logic [7:0] ob_reg, ob_next;
    logic       accept;

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = state_reg == S_IDLE;
    assign out_ch.valid = state_reg == S_OUT;
    assign out_ch.status = st_reg;
    assign out_ch.out_byte = ob_reg;
    assign data_byte = in_ch.data_byte;

    always_comb
    begin
        state_next = state_reg;
        mode_next = mode_reg;
        halt_next = halt_reg;
        st_next = st_reg;
        ob_next = ob_reg;
        ctl = '0;
        case (state_reg)
            S_RESET:
            begin
                ctl.clear_step = 1'b1;
                if (stat.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    st_next = ST_OK;
                    ob_next = 8'd0;
                    state_next = S_OUT;
                    if (in_ch.cmd == CMD_CLEAR)
                    begin
                        ctl.clear_start = 1'b1;
                        mode_next = MODE_READY;
                        halt_next = ST_OK;
                        state_next = S_CLEAR;
                    end
                    else if (mode_reg == MODE_HALT)
                        st_next = halt_reg;
                    else if (in_ch.cmd == CMD_LOAD)
                    begin
                        if (sym_code(in_ch.data_byte) != 4'd0 && stat.full)
                        begin
                            st_next = ST_FULL;
                            mode_next = MODE_HALT;
                            halt_next = ST_FULL;
                        end
                        else
                            ctl.load = 1'b1;
                    end
                    else if (in_ch.cmd == CMD_RUN)
                    begin
                        if (mode_reg == MODE_WAIT)
                            st_next = ST_NEED;
                        else
                        begin
                            ctl.budget_clr = 1'b1;
                            state_next = S_CHECK;
                        end
                    end
                    else if (mode_reg == MODE_WAIT)
                    begin
                        ctl.supply = 1'b1;
                        ctl.budget_clr = 1'b1;
                        mode_next = MODE_READY;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CLEAR:
            begin
                ctl.clear_step = 1'b1;
                if (stat.clear_done)
                    state_next = S_OUT;
            end
            S_CHECK:
            begin
                if (stat.at_end)
                begin
                    st_next = ST_DONE;
                    state_next = S_OUT;
                end
                else if (stat.budget_out)
                begin
                    st_next = ST_BUDGET;
                    state_next = S_OUT;
                end
                else
                begin
                    ctl.fetch = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_CHECK;
                case (stat.op)
                    OP_RIGHT:
                        if (stat.at_right)
                        begin
                            st_next = ST_OVER;
                            state_next = S_OUT;
                        end
                    OP_LEFT:
                        if (stat.at_left)
                        begin
                            st_next = ST_UNDER;
                            state_next = S_OUT;
                        end
                    OP_OUT:
                    begin
                        st_next = ST_OUTPUT;
                        ob_next = cell_value;
                        state_next = S_OUT;
                    end
                    OP_IN:
                    begin
                        st_next = ST_NEED;
                        mode_next = MODE_WAIT;
                        state_next = S_OUT;
                    end
                    OP_OPEN:
                        if (!stat.cell_zero && stat.stack_full)
                        begin
                            st_next = ST_LOOPFULL;
                            state_next = S_OUT;
                        end
                        else if (stat.cell_zero)
                            state_next = S_SKIPF;
                    OP_CLOSE:
                        if (stat.stack_empty)
                        begin
                            st_next = ST_UNMATCHED;
                            state_next = S_OUT;
                        end
                    default: state_next = S_CHECK;
                endcase
                if (st_next >= ST_UNDER && st_next <= ST_LOOPFULL)
                begin
                    mode_next = MODE_HALT;
                    halt_next = st_next;
                end
                else if (state_next == S_SKIPF)
                    ctl.skip_start = 1'b1;
                else if (stat.op != OP_IN)
                    ctl.exec = 1'b1;
                if (state_next == S_SKIPF)
                    ctl.exec = 1'b1;
            end
            S_SKIPF:
            begin
                // pc past the '[', depth one
                if (stat.at_end || stat.skip_done)
                    state_next = S_CHECK;
                else
                begin
                    ctl.fetch = 1'b1;
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                ctl.skip_step = 1'b1;
                state_next = S_SKIPF;
            end
            S_OUT:
                if (out_ch.ready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RESET;
            mode_reg <= MODE_READY;
            halt_reg <= ST_OK;
            st_reg <= ST_OK;
            ob_reg <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg <= mode_next;
            halt_reg <= halt_next;
            st_reg <= st_next;
            ob_reg <= ob_next;
        end
    end

    `ASSERT_CLK(a_out_byte_zero, clk, rst_n, (out_ch.valid && out_ch.status != ST_OUTPUT) |-> (out_ch.out_byte == 8'd0), "out_byte nonzero without output status")
    `ASSERT_CLK(a_no_overlap, clk, rst_n, !(in_ch.ready && out_ch.valid), "input taken while result pending")
    `ASSERT_CLK(a_halt_code, clk, rst_n, (mode_reg == MODE_HALT) |-> (halt_reg >= ST_UNDER && halt_reg <= ST_FULL), "halt without error code")
    `ASSERT_CLK(a_status_range, clk, rst_n, out_ch.valid |-> (out_ch.status <= ST_BUDGET), "status out of range")
endmodule

// ----- rtl/tape_language_interpreter.sv -----
`timescale 1ns / 1ps
// tape language interpreter
// in_ch: transactions of cmd (clear, load, run, supply) and data_byte.
// out_ch: one transaction per input transaction, out_byte and status.
// cfg_ch: writes step_budget (reset 65535); the user must write it only
// while the block is idle; the block itself does not enforce this.
// every input transaction answers with exactly one result, one at a time;
// in_ch.ready is low until the previous result has been taken.
// load and halted items show their result the cycle after acceptance.
// run and supply execute each instruction as a check and fetch step reading
// program and tape memories, then an execute step; skipping a loop on a zero
// cell scans each symbol with a fetch and a skip step; when the program ends
// or the budget runs out, a final check step comes before the result shows.
// clear sweeps the tape memory one cell a cycle.
// after reset the same sweep runs before in_ch.ready
// rises; cfg writes are taken at any time.
// a stalled out_ch holds its result and the block accepts nothing new.
module tape_language_interpreter #(
    parameter int PROGRAM_DEPTH = 4096,
    parameter int TAPE_DEPTH = 1024,
    parameter int LOOP_DEPTH = 64
) (
    input logic       clk,
    input logic       rst_n,
    tli_in_if.sink    in_ch,
    tli_out_if.source out_ch,
    tli_cfg_if.sink   cfg_ch
);
    import tli_pkg::*;

    tli_cmd_t    ctl;
    tli_stat_t   stat;
    logic [7:0]  cell_value;
    logic [7:0]  data_byte;
    logic [31:0] budget_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            budget_reg <= BUDGET_RESET;
        else if (cfg_ch.valid)
            budget_reg <= cfg_ch.data;
    end

    tli_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .stat(stat),
        .cell_value(cell_value),
        .ctl(ctl),
        .data_byte(data_byte)
    );

    tli_datapath #(
        .PROGRAM_DEPTH(PROGRAM_DEPTH),
        .TAPE_DEPTH(TAPE_DEPTH),
        .LOOP_DEPTH(LOOP_DEPTH)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(ctl),
        .data_byte(data_byte),
        .step_budget(budget_reg),
        .stat(stat),
        .cell_value(cell_value)
    );
endmodule
